// ----- sv/ddm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ddm_pkg;

  localparam int CHAN_W    = 12;
  localparam int SPEED_W   = 8;
  localparam int LEN_W     = 5;
  localparam int LEN_MAX   = (1 << LEN_W) - 1;
  localparam int CFG_IDX_W = 3;
  localparam int MODE_W    = 2;

  typedef logic [CHAN_W-1:0] chan_t;

  localparam logic [MODE_W-1:0] CMD_MOVE    = 2'd0;
  localparam logic [MODE_W-1:0] CMD_STOP    = 2'd1;
  localparam logic [MODE_W-1:0] CMD_REVERSE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_MID     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_SETTING   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LENGTH = 3'd5;

  localparam chan_t RST_SIGNAL_MIN   = 12'd1000;
  localparam chan_t RST_SIGNAL_MID   = 12'd1500;
  localparam chan_t RST_SIGNAL_MAX   = 12'd2000;
  localparam chan_t RST_DEADBAND     = 12'd20;
  localparam chan_t RST_MODE_SETTING = 12'd1500;
  localparam logic [LEN_W-1:0] RST_HISTORY_LENGTH = 5'd0;

  typedef struct packed {
    chan_t             signal_min;
    chan_t             signal_mid;
    chan_t             signal_max;
    chan_t             deadband;
    chan_t             mode_setting;
    logic [LEN_W-1:0]  history_length;
  } cfg_t;

endpackage

`default_nettype wire

// ----- sv/ddm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ddm_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/ddm_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ddm_div #(
  parameter int DW = 20,
  parameter int VW = 12
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic      [DW-1:0] quotient,
  output logic      [VW-1:0] remainder
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt;
  logic [VW-1:0] dvs;
  logic [VW:0]   rem_shift;
  logic [VW:0]   diff;
  logic          fits;

  assign rem_shift = {remainder, quotient[DW-1]};
  assign diff      = rem_shift - {1'b0, dvs};
  assign fits      = rem_shift >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient  <= dividend;
        remainder <= '0;
        dvs       <= divisor;
        cnt       <= CW'(DW);
      end else if (cnt != '0) begin
        quotient  <= {quotient[DW-2:0], fits};
        remainder <= fits ? diff[VW-1:0] : rem_shift[VW-1:0];
        cnt       <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/ddm_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ddm_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic [ddm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ddm_pkg::CHAN_W-1:0]    cfg_data,
  output logic                               cfg_ready,
  output ddm_pkg::cfg_t                      cfg
);

  import ddm_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.signal_min     <= RST_SIGNAL_MIN;
      cfg.signal_mid     <= RST_SIGNAL_MID;
      cfg.signal_max     <= RST_SIGNAL_MAX;
      cfg.deadband       <= RST_DEADBAND;
      cfg.mode_setting   <= RST_MODE_SETTING;
      cfg.history_length <= RST_HISTORY_LENGTH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIGNAL_MIN:     cfg.signal_min     <= cfg_data;
        REG_SIGNAL_MID:     cfg.signal_mid     <= cfg_data;
        REG_SIGNAL_MAX:     cfg.signal_max     <= cfg_data;
        REG_DEADBAND:       cfg.deadband       <= cfg_data;
        REG_MODE_SETTING:   cfg.mode_setting   <= cfg_data;
        REG_HISTORY_LENGTH: cfg.history_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/differential_drive_mixer_core.sv -----
// Differential drive mixer: turns throttle and steering channel values into
// left and right PWM levels with direction bits.
// Item channel (item_valid/item_stall) carries mode, throttle and steering.
// Result channel (result_valid/result_stall) carries the two speeds and two
// direction bits; commands that are ignored produce no result transfer.
// Configuration writes arrive on cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high and writes belong to idle periods.
// One item is worked on at a time; item_stall is high while it is in flight.
// Move and stop run the throttle scale division, and in soft mode also the
// steering one, on one restoring divider, one quotient bit per cycle; that
// divider first reduces the ring pointer when the history length was
// shortened to or below it. Reverse steps the pointer back and loads that
// entry. The next item is taken the cycle after a result loads.
// A finished result waits in the output register; while the receiver stalls
// the next item is still taken, and it holds in its last step until the
// register frees. Reset restores the register defaults, empties the history
// (entries read as zero until written) and clears the ring pointer.
`timescale 1ns / 1ps
`default_nettype none

module differential_drive_mixer_core #(
  parameter int HISTORY_DEPTH = 16,
  parameter int PWM_MAX       = 255
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic [ddm_pkg::MODE_W-1:0]    mode,
  input  wire logic [ddm_pkg::CHAN_W-1:0]    throttle,
  input  wire logic [ddm_pkg::CHAN_W-1:0]    steering,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic      [ddm_pkg::SPEED_W-1:0]   left_speed,
  output logic      [ddm_pkg::SPEED_W-1:0]   right_speed,
  output logic                               left_forward,
  output logic                               right_forward,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ddm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ddm_pkg::CHAN_W-1:0]    cfg_data
);

  import ddm_pkg::*;

  localparam int SW      = (PWM_MAX > 1) ? $clog2(PWM_MAX + 1) : 1;
  localparam int PROD_W  = CHAN_W + SW;
  localparam int PW      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int ENTRY_W = 2 * SW + 2;
  localparam logic [LEN_W-1:0] LEN_CAP =
    LEN_W'((HISTORY_DEPTH < LEN_MAX) ? HISTORY_DEPTH : LEN_MAX);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MOD, S_REV_STEP, S_REV_READ, S_REV_LOAD,
    S_MUL_Y, S_DIV_Y_GO, S_DIV_Y, S_MUL_X, S_DIV_X_GO, S_DIV_X, S_MIX
  } state_t;

  state_t state;
  cfg_t   cfg;

  logic              cmd_rev;
  chan_t             y, x;
  logic [PW-1:0]     ptr, p;
  logic [PROD_W-1:0] prod;
  logic [SW-1:0]     fy, trimmed;
  logic [HISTORY_DEPTH-1:0] ring_valid;
  logic              rd_valid;

  logic [LEN_W-1:0]   len;
  chan_t              ptr_ext, len_ext, p_inc;
  logic [PW-1:0]      ptr_adv, p_dec;
  logic               in_range, need_mod, d_pos, soft_mode, out_free, res_load;
  chan_t              d, dy, dx, abs_y, abs_x;
  logic               live_y, live_x, steer_right, fwd;
  logic [SW-1:0]      fy_sat, trim_val, ls, rs;
  logic               lf, rf, nonzero, ram_we;
  logic               div_start, div_done;
  logic [PROD_W-1:0]  div_dividend, div_quo;
  chan_t              div_divisor, div_rem;
  logic [ENTRY_W-1:0] wr_entry, rd_data, rd_entry;

  ddm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  ddm_div #(.DW(PROD_W), .VW(CHAN_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  ddm_ram #(.WIDTH(ENTRY_W), .DEPTH(HISTORY_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (p),
    .wdata (wr_entry),
    .raddr (p),
    .rdata (rd_data)
  );

  assign item_stall = (state != S_IDLE);
  assign out_free   = !result_valid || !result_stall;
  assign res_load   = out_free && ((state == S_MIX) || (state == S_REV_LOAD));

  // pointer arithmetic
  assign len     = (cfg.history_length > LEN_CAP) ? LEN_CAP : cfg.history_length;
  assign ptr_ext = CHAN_W'(ptr);
  assign len_ext = CHAN_W'(len);
  assign p_inc   = CHAN_W'(p) + 1'b1;
  assign ptr_adv = (p_inc == len_ext) ? '0 : PW'(p_inc);
  assign p_dec   = (p == '0) ? PW'(len - 1'b1) : PW'(p - 1'b1);
  assign need_mod = (len != '0) && (ptr_ext >= len_ext);

  assign in_range = (y >= cfg.signal_min) && (x >= cfg.signal_min) &&
                    (y <= cfg.signal_max) && (x <= cfg.signal_max);

  // channel shaping
  assign d_pos  = cfg.signal_mid > cfg.signal_min;
  assign d      = cfg.signal_mid - cfg.signal_min;
  assign dy     = (y > cfg.signal_mid) ? y - cfg.signal_mid : cfg.signal_mid - y;
  assign dx     = (x > cfg.signal_mid) ? x - cfg.signal_mid : cfg.signal_mid - x;
  assign live_y = dy >= cfg.deadband;
  assign live_x = dx >= cfg.deadband;
  assign abs_y  = live_y ? dy : '0;
  assign abs_x  = live_x ? dx : '0;
  assign steer_right = live_x && (x > cfg.signal_mid);
  assign fwd    = live_y && (y > cfg.signal_mid);
  assign soft_mode = cfg.mode_setting == cfg.signal_mid;

  assign fy_sat   = (div_quo > PROD_W'(PWM_MAX)) ? SW'(PWM_MAX) : SW'(div_quo);
  assign trim_val = (div_quo >= PROD_W'(fy)) ? '0 : fy - SW'(div_quo);

  always_comb begin
    ls = fy;
    rs = fy;
    lf = fwd;
    rf = fwd;
    if (soft_mode) begin
      if (steer_right) begin
        rs = trimmed;
      end else begin
        ls = trimmed;
      end
    end else if (abs_x > cfg.deadband) begin
      lf = steer_right;
      rf = !steer_right;
    end
  end

  assign nonzero  = (ls != '0) || (rs != '0);
  assign wr_entry = {ls, rs, lf, rf};
  assign ram_we   = (state == S_MIX) && out_free && (len != '0) && nonzero;
  assign rd_entry = rd_valid ? rd_data : '0;

  // shared divider operand selection
  assign div_start    = ((state == S_PREP) && need_mod) ||
                        (state == S_DIV_Y_GO) || (state == S_DIV_X_GO);
  assign div_dividend = (state == S_PREP) ? PROD_W'(ptr) : prod;
  assign div_divisor  = (state == S_PREP) ? len_ext : d;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      ptr          <= '0;
      ring_valid   <= '0;
    end else begin
      rd_valid <= ring_valid[p];
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            cmd_rev <= (mode == CMD_REVERSE);
            case (mode)
              CMD_MOVE, CMD_REVERSE: begin
                y     <= throttle;
                x     <= steering;
                state <= S_PREP;
              end
              CMD_STOP: begin
                y     <= cfg.signal_mid;
                x     <= cfg.signal_mid;
                state <= S_PREP;
              end
              default: ;
            endcase
          end
        end
        S_PREP: begin
          if (cmd_rev && (len == '0)) begin
            state <= S_IDLE;
          end else if (!cmd_rev && !in_range) begin
            state <= S_IDLE;
          end else if (need_mod) begin
            state <= S_MOD;
          end else begin
            p     <= ptr;
            state <= cmd_rev ? S_REV_STEP : S_MUL_Y;
          end
        end
        S_MOD: begin
          if (div_done) begin
            p     <= PW'(div_rem);
            state <= cmd_rev ? S_REV_STEP : S_MUL_Y;
          end
        end
        S_REV_STEP: begin
          p     <= p_dec;
          ptr   <= p_dec;
          state <= S_REV_READ;
        end
        S_REV_READ: begin
          state <= S_REV_LOAD;
        end
        S_REV_LOAD: begin
          if (out_free) begin
            left_speed    <= SPEED_W'(rd_entry[ENTRY_W-1:SW+2]);
            right_speed   <= SPEED_W'(rd_entry[SW+1:2]);
            left_forward  <= !rd_entry[1];
            right_forward <= !rd_entry[0];
            state         <= S_IDLE;
          end
        end
        S_MUL_Y: begin
          if (!d_pos) begin
            fy      <= '0;
            trimmed <= '0;
            state   <= S_MIX;
          end else begin
            prod  <= PROD_W'(abs_y) * PROD_W'(PWM_MAX);
            state <= S_DIV_Y_GO;
          end
        end
        S_DIV_Y_GO: begin
          state <= S_DIV_Y;
        end
        S_DIV_Y: begin
          if (div_done) begin
            fy    <= fy_sat;
            state <= soft_mode ? S_MUL_X : S_MIX;
          end
        end
        S_MUL_X: begin
          prod  <= PROD_W'(abs_x) * PROD_W'(fy);
          state <= S_DIV_X_GO;
        end
        S_DIV_X_GO: begin
          state <= S_DIV_X;
        end
        S_DIV_X: begin
          if (div_done) begin
            trimmed <= trim_val;
            state   <= S_MIX;
          end
        end
        S_MIX: begin
          if (out_free) begin
            left_speed    <= SPEED_W'(ls);
            right_speed   <= SPEED_W'(rs);
            left_forward  <= lf;
            right_forward <= rf;
            if (ram_we) begin
              ring_valid[p] <= 1'b1;
              ptr           <= ptr_adv;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
